@@ rtl/gkrs_pkg.sv @@
// ----------------------------------------------------------------------------
// gkrs_pkg
// Shared constants and the fixed-point exponential used to build the CDF
// tables of the Gaussian kernel radius sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package gkrs_pkg;

    // Default number of table bins
    localparam int TABLE_BINS_DEF = 400;

    // Q32 one, -A in Q32, 4*pi*N in Q24, ln 2 in Q32
    localparam logic [63:0] ONE_Q32 = 64'h0000_0001_0000_0000;
    localparam logic [63:0] AQ      = 64'd25161497036;
    localparam logic [63:0] KQ      = 64'd541429348;
    localparam logic [63:0] LN2Q    = 64'd2977044472;

    // Result fraction bits
    localparam int FRAC_W = 16;
    localparam int RADIUS_W = 17;

    // exp(-x) in Q32 for x in Q32, by range reduction and a 25-term series
    function automatic logic [63:0] expneg_q32(input logic [63:0] x);
        logic [63:0] n;
        logic [63:0] r;
        logic [63:0] term;
        longint      s;
        n    = x / LN2Q;
        r    = x - n * LN2Q;
        term = ONE_Q32;
        s    = longint'(ONE_Q32);
        if (n >= 64'd63) begin
            return 64'd0;
        end
        for (int i = 1; i <= 24; i++) begin
            term = ((term * r) >> 32) / 64'(i);
            if ((i % 2) == 1) begin
                s = s - longint'(term);
            end else begin
                s = s + longint'(term);
            end
        end
        if (s < 0) begin
            s = 0;
        end
        return 64'(s) >> n;
    endfunction

endpackage

`default_nettype wire

@@ rtl/gkrs_srch_stage.sv @@
// ----------------------------------------------------------------------------
// gkrs_srch_stage
// One bit of the CDF search: try setting bit BIT_POS of the bin index and keep
// it when the table entry there does not exceed the deviate. Tracks the CDF
// values at both edges of the current bin.
// ----------------------------------------------------------------------------
`default_nettype none

module gkrs_srch_stage #(
    parameter int TABLE_BINS = 400,
    parameter int KW         = 9,
    parameter int BIT_POS    = 0
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          en,
    input  wire logic          valid_in,
    input  wire logic [31:0]   x_in,
    input  wire logic [KW-1:0] k_in,
    input  wire logic [32:0]   lo_in,
    input  wire logic [32:0]   hi_in,
    output logic               valid_out,
    output logic [31:0]        x_out,
    output logic [KW-1:0]      k_out,
    output logic [32:0]        lo_out,
    output logic [32:0]        hi_out
);
    import gkrs_pkg::*;

    localparam int IW    = (KW - BIT_POS - 1 > 0) ? KW - BIT_POS - 1 : 1;
    localparam int TSIZE = 1 << (KW - BIT_POS - 1);
    localparam logic [63:0] NN = 64'(TABLE_BINS) * 64'(TABLE_BINS);

    typedef logic [TSIZE-1:0][32:0] tbl_t;

    // Entries at indexes with bit BIT_POS set and lower bits clear
    function automatic tbl_t build_tbl();
        tbl_t        tbl;
        logic [63:0] acc;
        logic [63:0] k2;
        logic [63:0] e;
        logic [63:0] t;
        logic [63:0] inc;
        for (int j = 0; j < TSIZE; j++) begin
            tbl[j] = 33'(ONE_Q32);
        end
        acc = 64'd0;
        for (int k = 1; k < TABLE_BINS; k++) begin
            k2  = 64'(k) * 64'(k);
            e   = expneg_q32(AQ * k2 / NN);
            t   = e * k2 / NN;
            inc = ((t * KQ) / 64'(TABLE_BINS)) >> 24;
            acc = acc + inc;
            if (acc > ONE_Q32) begin
                acc = ONE_Q32;
            end
            if (((k >> BIT_POS) % 2) == 1 && (k % (1 << BIT_POS)) == 0) begin
                tbl[k >> (BIT_POS + 1)] = 33'(acc);
            end
        end
        return tbl;
    endfunction

    localparam tbl_t TBL = build_tbl();

    logic [IW-1:0]  idx;
    logic [32:0]    entry;
    logic           take;
    logic [KW-1:0]  k_next;
    logic [32:0]    lo_next;
    logic [32:0]    hi_next;

    // Compare the candidate entry against the deviate
    always_comb begin
        idx     = IW'(k_in >> (BIT_POS + 1));
        entry   = TBL[idx];
        take    = (entry <= {1'b0, x_in});
        k_next  = k_in;
        lo_next = lo_in;
        hi_next = hi_in;
        if (take) begin
            k_next  = k_in | KW'(1 << BIT_POS);
            lo_next = entry;
        end else begin
            hi_next = entry;
        end
    end

    // Advance the stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_out <= 1'b0;
        end else if (en) begin
            valid_out <= valid_in;
        end
        if (en) begin
            x_out  <= x_in;
            k_out  <= k_next;
            lo_out <= lo_next;
            hi_out <= hi_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/gkrs_div_stage.sv @@
// ----------------------------------------------------------------------------
// gkrs_div_stage
// One step of restoring division: doubles the partial remainder, subtracts
// the divisor when it fits and shifts one quotient bit in.
// ----------------------------------------------------------------------------
`default_nettype none

module gkrs_div_stage #(
    parameter int DW = 42
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        en,
    input  wire logic        valid_in,
    input  wire logic [DW-1:0] rem_in,
    input  wire logic [DW-1:0] den_in,
    input  wire logic [gkrs_pkg::FRAC_W-1:0] q_in,
    output logic             valid_out,
    output logic [DW-1:0]    rem_out,
    output logic [DW-1:0]    den_out,
    output logic [gkrs_pkg::FRAC_W-1:0] q_out
);
    import gkrs_pkg::*;

    logic [DW:0]   rem2;
    logic [DW:0]   diff;
    logic          fits;

    // Trial subtract of the doubled remainder
    always_comb begin
        rem2 = {rem_in, 1'b0};
        diff = rem2 - {1'b0, den_in};
        fits = (rem2 >= {1'b0, den_in});
    end

    // Advance the stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_out <= 1'b0;
        end else if (en) begin
            valid_out <= valid_in;
        end
        if (en) begin
            rem_out <= fits ? diff[DW-1:0] : rem2[DW-1:0];
            den_out <= den_in;
            q_out   <= {q_in[FRAC_W-2:0], fits};
        end
    end

endmodule

`default_nettype wire

@@ rtl/gaussian_kernel_radius_sampler_top.sv @@
// ----------------------------------------------------------------------------
// gaussian_kernel_radius_sampler_top
// Inverse-transform sampler of a truncated Gaussian kernel radius.
// ----------------------------------------------------------------------------
// Takes one unsigned Q0.32 uniform deviate per item and returns a Q0.16 radius
// in [0,1) drawn through a tabulated CDF. One item enters every cycle when the
// output is taken; the pipeline has clog2(TABLE_BINS) search stages (one index
// bit each, own constant table per bit), three interpolation stages and 16
// restoring-division stages. A stalled output holds the whole pipeline. The
// tables are constants built at elaboration.
`default_nettype none

module gaussian_kernel_radius_sampler_top #(
    parameter int TABLE_BINS = gkrs_pkg::TABLE_BINS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] uniform_value
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata    // [16:0] radius
);
    import gkrs_pkg::*;

    localparam int KW = $clog2(TABLE_BINS);
    localparam int DW = 33 + KW;

    logic en;

    // Search chain, index bit KW-1 first
    logic          sv [KW+1];
    logic [31:0]   sx [KW+1];
    logic [KW-1:0] sk [KW+1];
    logic [32:0]   slo [KW+1];
    logic [32:0]   shi [KW+1];

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en && aresetn;

    assign sv[0]  = s_tvalid;
    assign sx[0]  = s_tdata;
    assign sk[0]  = '0;
    assign slo[0] = '0;
    assign shi[0] = 33'(ONE_Q32);

    for (genvar i = 0; i < KW; i++) begin : g_srch
        gkrs_srch_stage #(
            .TABLE_BINS(TABLE_BINS),
            .KW(KW),
            .BIT_POS(KW - 1 - i)
        ) u_stage (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .valid_in(sv[i]), .x_in(sx[i]), .k_in(sk[i]),
            .lo_in(slo[i]), .hi_in(shi[i]),
            .valid_out(sv[i+1]), .x_out(sx[i+1]), .k_out(sk[i+1]),
            .lo_out(slo[i+1]), .hi_out(shi[i+1])
        );
    end

    // Interpolation front end: bin width, offset, products, dividend
    logic          m0_valid_reg, m1_valid_reg, m2_valid_reg;
    logic [32:0]   d_reg;
    logic [31:0]   r0_reg, r1_reg;
    logic [KW-1:0] k0_reg;
    logic [DW-1:0] prod_reg, den1_reg, den2_reg, a_reg;
    logic [32:0]   r_wide;

    assign r_wide = {1'b0, sx[KW]} - slo[KW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m0_valid_reg <= 1'b0;
            m1_valid_reg <= 1'b0;
            m2_valid_reg <= 1'b0;
        end else if (en) begin
            m0_valid_reg <= sv[KW];
            m1_valid_reg <= m0_valid_reg;
            m2_valid_reg <= m1_valid_reg;
        end
        if (en) begin
            d_reg    <= shi[KW] - slo[KW];
            r0_reg   <= r_wide[31:0];
            k0_reg   <= sk[KW];
            prod_reg <= DW'(k0_reg) * DW'(d_reg);
            den1_reg <= DW'(d_reg) * DW'(TABLE_BINS);
            r1_reg   <= r0_reg;
            a_reg    <= prod_reg + DW'(r1_reg);
            den2_reg <= den1_reg;
        end
    end

    // Division chain, one quotient bit per stage
    logic              dv [FRAC_W+1];
    logic [DW-1:0]     drem [FRAC_W+1];
    logic [DW-1:0]     dden [FRAC_W+1];
    logic [FRAC_W-1:0] dq [FRAC_W+1];

    assign dv[0]   = m2_valid_reg;
    assign drem[0] = a_reg;
    assign dden[0] = den2_reg;
    assign dq[0]   = '0;

    for (genvar j = 0; j < FRAC_W; j++) begin : g_div
        gkrs_div_stage #(.DW(DW)) u_stage (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .valid_in(dv[j]), .rem_in(drem[j]), .den_in(dden[j]), .q_in(dq[j]),
            .valid_out(dv[j+1]), .rem_out(drem[j+1]), .den_out(dden[j+1]),
            .q_out(dq[j+1])
        );
    end

    assign m_tvalid = dv[FRAC_W];
    assign m_tdata  = {(24 - RADIUS_W)'(0), 1'b0, dq[FRAC_W]};

    // The search brackets the deviate within its bin
    a_bracket: assert property (@(posedge aclk) disable iff (!aresetn)
        sv[KW] |-> (slo[KW] <= {1'b0, sx[KW]}) && ({1'b0, sx[KW]} < shi[KW]))
        else $error("search result does not bracket the deviate");

    // A found bin is never empty
    a_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        m0_valid_reg |-> (d_reg != '0))
        else $error("empty bin reached interpolation");

    // The dividend stays below the divisor entering the division
    a_frac: assert property (@(posedge aclk) disable iff (!aresetn)
        m2_valid_reg |-> (a_reg < den2_reg))
        else $error("interpolation dividend out of range");

    // A stalled result holds steady until taken
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(dq[FRAC_W]) && m_tvalid)
        else $error("stalled result changed");

endmodule

`default_nettype wire
